// ===== rtl/bmcc_pkg.sv =====
// Package for the bounded multiset combination counter.
// Holds shared constants and widths; no dependencies.
`default_nettype none
package bmcc_pkg;
	localparam int unsigned MAX_TYPES_DEF = 8;
	localparam int unsigned ACC_W = 64;
	localparam int unsigned OUT_W = 63;
	localparam int unsigned LIM_W = 8;
endpackage
`default_nettype wire

// ===== rtl/bmcc_mac.sv =====
// Bit-serial step unit: c_out = c_in * a / b, exact division, one bit a cycle.
// Depends on bmcc_pkg.
`default_nettype none
module bmcc_mac
	import bmcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [ACC_W-1:0]  c_in,
	input  wire logic [8:0]        a_in,
	input  wire logic [3:0]        b_in,
	output logic                   done,
	output logic [ACC_W-1:0]       c_out
);
	localparam int unsigned PW = ACC_W + 9;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MUL  = 3'b010,
		S_DIV  = 3'b100
	} st_t;

	st_t               st_q;
	logic [PW-1:0]     prod_q;
	logic [PW-1:0]     mc_q;
	logic [8:0]        ma_q;
	logic [3:0]        b_q;
	logic [4:0]        rem_q;
	logic [ACC_W-1:0]  quo_q;
	logic [6:0]        cnt_q;
	logic [4:0]        rem_sh;

	assign rem_sh = {rem_q[3:0], prod_q[PW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (go) begin
						st_q <= S_MUL;
						cnt_q <= 7'd9;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= S_DIV;
						cnt_q <= 7'(PW);
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= S_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && go) begin
			prod_q <= '0;
			mc_q <= {9'd0, c_in};
			ma_q <= a_in;
			b_q <= b_in;
		end else if (st_q == S_MUL) begin
			if (ma_q[0])
				prod_q <= prod_q + mc_q;
			mc_q <= mc_q << 1;
			ma_q <= ma_q >> 1;
			rem_q <= '0;
			quo_q <= '0;
		end else if (st_q == S_DIV) begin
			prod_q <= prod_q << 1;
			if (rem_sh >= {1'b0, b_q}) begin
				rem_q <= rem_sh - {1'b0, b_q};
				quo_q <= {quo_q[ACC_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[ACC_W-2:0], 1'b0};
			end
		end
	end

	assign c_out = quo_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> b_q != 4'd0) else $error("divide by zero");
	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == S_DIV) else $error("done out of sequence");
	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == S_IDLE) else $error("unit not idle after done");
endmodule
`default_nettype wire

// ===== rtl/bounded_multiset_combination_count.sv =====
// Top level of the bounded multiset combination counter.
// Depends on bmcc_pkg and bmcc_mac.
//
// Requests load one limit each. The request marked last
// starts inclusion-exclusion over all 2^n subsets of the n stored types;
// each subset first forms its sum, then, if that sum does not exceed r,
// takes n-1 binomial steps in the bit-serial multiply and divide unit and
// adds the term. The count appears for one cycle on combo_count
// with done high; busy is high from the marked request until then. The
// receiver cannot stall.
`default_nettype none
module bounded_multiset_combination_count
	import bmcc_pkg::*;
#(
	parameter int unsigned MAX_TYPES = MAX_TYPES_DEF
)(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [LIM_W-1:0]  limit,
	input  wire logic              last,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,
	output logic                   done,
	output logic [OUT_W-1:0]       combo_count
);
	localparam int unsigned IW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
	localparam int unsigned CW = $clog2(MAX_TYPES + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SUM  = 5'b00010,
		S_BIN  = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT  = 5'b10000
	} st_t;

	st_t                   st_q;
	logic [7:0]            r_q;
	logic [LIM_W-1:0]      lim_q [MAX_TYPES];
	logic [CW-1:0]         cnt_q;
	logic [MAX_TYPES:0]    mask_q;
	logic [CW-1:0]         bit_q;
	logic [12:0]           used_q;
	logic                  odd_q;
	logic [ACC_W-1:0]      sum_q;
	logic [ACC_W-1:0]      c_q;
	logic [3:0]            i_q;
	logic [8:0]            m_q;
	logic                  go;
	logic                  mdone;
	logic [ACC_W-1:0]      mres;
	logic [12:0]           m_full;

	assign busy = (st_q != S_IDLE);
	assign m_full = {5'd0, r_q} - used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			r_q <= '0;
		else if (cfg_we)
			r_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
			go <= 1'b0;
		end else begin
			done <= 1'b0;
			go <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						if (cnt_q < CW'(MAX_TYPES))
							cnt_q <= cnt_q + CW'(1);
						if (last)
							st_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (mask_q[cnt_q])
						st_q <= S_OUT;
					else if (bit_q == cnt_q) begin
						if (m_full[12] || used_q > {5'd0, r_q} || cnt_q == CW'(1))
							st_q <= S_SUM;
						else
							st_q <= S_BIN;
					end
				end
				S_BIN: begin
					if (i_q == 4'(cnt_q))
						st_q <= S_SUM;
					else begin
						go <= 1'b1;
						st_q <= S_WAIT;
					end
				end
				S_WAIT: if (mdone) st_q <= S_BIN;
				S_OUT: begin
					done <= 1'b1;
					cnt_q <= '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start && cnt_q < CW'(MAX_TYPES))
			lim_q[cnt_q[IW-1:0]] <= limit;
		unique case (st_q)
			S_IDLE: begin
				mask_q <= '0;
				bit_q <= '0;
				used_q <= '0;
				odd_q <= 1'b0;
				sum_q <= '0;
			end
			S_SUM: begin
				if (bit_q != cnt_q) begin
					if (mask_q[bit_q]) begin
						used_q <= used_q + 13'(lim_q[bit_q[IW-1:0]]) + 13'd1;
						odd_q <= ~odd_q;
					end
					bit_q <= bit_q + CW'(1);
				end else begin
					if (!(used_q > {5'd0, r_q})) begin
						if (cnt_q == CW'(1))
							sum_q <= odd_q ? sum_q - 64'd1 : sum_q + 64'd1;
					end
					m_q <= m_full[8:0];
					c_q <= 64'd1;
					i_q <= 4'd1;
					if (used_q > {5'd0, r_q} || cnt_q == CW'(1)) begin
						mask_q <= mask_q + {{MAX_TYPES{1'b0}}, 1'b1};
						bit_q <= '0;
						used_q <= '0;
						odd_q <= 1'b0;
					end
				end
			end
			S_BIN: begin
				if (i_q == 4'(cnt_q)) begin
					sum_q <= odd_q ? sum_q - c_q : sum_q + c_q;
					mask_q <= mask_q + {{MAX_TYPES{1'b0}}, 1'b1};
					bit_q <= '0;
					used_q <= '0;
					odd_q <= 1'b0;
				end
			end
			S_WAIT: begin
				if (mdone) begin
					c_q <= mres;
					i_q <= i_q + 4'd1;
				end
			end
			S_OUT: begin
				combo_count <= sum_q[ACC_W-1] ? {OUT_W{1'b1}} : sum_q[OUT_W-1:0];
			end
			default: ;
		endcase
	end

	bmcc_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.c_in  (c_q),
		.a_in  (m_q + 9'(i_q)),
		.b_in  (i_q),
		.done  (mdone),
		.c_out (mres)
	);

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_TYPES)) else $error("type count overflow");
endmodule
`default_nettype wire

// ===== bench/bmcc_checker.sv =====
// Checker for the bounded multiset combination counter.
// Watches requests, configuration writes and results, predicts each count
// and compares it with the block's output. Depends on bmcc_pkg.
`timescale 1ns / 1ps
module bmcc_checker
	import bmcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire logic [LIM_W-1:0] limit,
	input  wire logic             last,
	input  wire logic             cfg_we,
	input  wire logic [7:0]       cfg_wdata,
	input  wire logic             done,
	input  wire logic [OUT_W-1:0] combo_count,
	output int                    errors,
	output int                    pending,
	output int                    counts_seen
);
	logic [LIM_W-1:0] stored_limits [MAX_TYPES_DEF];
	int unsigned stored_types;
	logic [7:0] r_size;
	logic [OUT_W-1:0] count_queue [$];

	function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Multiset coefficient C(n + m - 1, m) with common factors taken out first.
	function automatic longint unsigned multiset_coef(longint unsigned n, longint unsigned m);
		longint unsigned c, g, d;
		c = 1;
		for (longint unsigned i = 1; i < n; i++) begin
			g = gcd64(c, i);
			d = i / g;
			c = c / g;
			c = c * ((m + i) / d);
		end
		return c;
	endfunction

	function automatic logic [OUT_W-1:0] bounded_count();
		longint unsigned total;
		int m;
		bit odd;
		total = 0;
		for (int mask = 0; mask < (1 << stored_types); mask++) begin
			m = r_size;
			odd = 0;
			for (int i = 0; i < stored_types; i++) begin
				if (mask[i]) begin
					m -= int'(stored_limits[i]) + 1;
					odd = !odd;
				end
			end
			if (m >= 0) begin
				if (odd)
					total -= multiset_coef(stored_types, m);
				else
					total += multiset_coef(stored_types, m);
			end
		end
		if (total[63])
			return {OUT_W{1'b1}};
		return total[OUT_W-1:0];
	endfunction

	assign pending = count_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_types = 0;
			r_size <= 8'd0;
			errors <= 0;
			counts_seen <= 0;
			count_queue.delete();
		end else begin
			if (cfg_we)
				r_size <= cfg_wdata;
			if (start && !busy) begin
				if (stored_types < MAX_TYPES_DEF) begin
					stored_limits[stored_types] = limit;
					stored_types = stored_types + 1;
				end
				if (last) begin
					count_queue.push_back(bounded_count());
					stored_types = 0;
				end
			end
			if (done) begin
				counts_seen <= counts_seen + 1;
				if (count_queue.size() == 0) begin
					$display("%0t: unexpected count, expected none, actual %0d", $time,
						combo_count);
					errors <= errors + 1;
				end else begin
					if (combo_count !== count_queue[0]) begin
						$display("%0t: combo_count mismatch, expected %0d, actual %0d",
							$time, count_queue[0], combo_count);
						errors <= errors + 1;
					end
					void'(count_queue.pop_front());
				end
			end
		end
	end
endmodule

// ===== bench/tb_bounded_multiset_combination_count.sv =====
// Testbench top for the bounded multiset combination counter.
// Drives directed and random multisets and r settings, and gives the verdict
// from the failure count of bmcc_checker. Depends on bmcc_pkg and the block.
`timescale 1ns / 1ps
module tb_bounded_multiset_combination_count;
	import bmcc_pkg::*;

	localparam int STALL_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [LIM_W-1:0] limit = '0;
	logic last = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic busy, done;
	logic [OUT_W-1:0] combo_count;
	int errors, pending, counts_seen;
	int requests_sent = 0;
	int stall_cycles = 0;
	bit steady = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	bounded_multiset_combination_count u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .limit(limit),
		.last(last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.combo_count(combo_count)
	);

	bmcc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .limit(limit),
		.last(last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.combo_count(combo_count), .errors(errors), .pending(pending),
		.counts_seen(counts_seen)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_request(input logic [LIM_W-1:0] lim, input logic lst);
		if (!steady && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		start <= 1'b1;
		limit <= lim;
		last <= lst;
		do @(posedge clk); while (busy);
		requests_sent++;
	endtask

	task automatic set_r(input logic [7:0] r);
		start <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_multiset(input int n, input bit wide);
		logic [LIM_W-1:0] lim;
		for (int i = 0; i < n; i++) begin
			lim = wide ? LIM_W'($urandom_range(255)) : LIM_W'($urandom_range(12));
			send_request(lim, i == n - 1);
		end
	endtask

	initial begin
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_r(8'd0);
		send_request(8'd0, 1'b1);
		send_request(8'd255, 1'b0);
		send_request(8'd0, 1'b1);
		set_r(8'd255);
		send_request(8'd255, 1'b1);
		send_request(8'd0, 1'b0);
		send_request(8'd255, 1'b0);
		send_request(8'd0, 1'b1);
		set_r(8'd7);
		send_request(8'd1, 1'b0);
		send_request(8'd2, 1'b1);
		// More types than the block stores; the extra limits are dropped.
		set_r(8'd20);
		for (int i = 0; i < 10; i++)
			send_request(LIM_W'(i), i == 9);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_r(8'd255);
				1: set_r(8'd0);
				default: set_r(8'($urandom_range(1, 254)));
			endcase
			steady = (phase == 3);
			for (int k = 0; k < 25; k++) begin
				n = ($urandom_range(99) < 4) ? $urandom_range(5, 6) : $urandom_range(1, 4);
				send_multiset(n, $urandom_range(1));
			end
		end
		steady = 0;
		set_r(8'd200);
		send_multiset(8, 1);

		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d limit requests, checked %0d counts over r = 0, 255 and random.",
			requests_sent, counts_seen);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
